// ===== src/kssm_pkg.sv =====
`timescale 1ns / 1ps
// Package: widths, constants and decode helpers for the keypad scanner / display mux.
package kssm_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned DigitW     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int unsigned LineW      = 4;
  localparam int unsigned KeyW       = 5;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PeriodW    = 8;

  localparam logic [PeriodW-1:0] ScanPeriodReset = 8'd20;
  localparam logic [KeyW-1:0]    KeyNone         = '0;
  localparam logic [KeyW-1:0]    KeyMax          = 5'd16;
  localparam logic [ByteW-1:0]   SegBlank        = 8'hFF;

  // Active-low patterns, bit0=a .. bit6=g, bit7 (dp) off.
  localparam logic [ByteW-1:0] SegTable [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };

  // Index of highest set bit, 0 when none set.
  function automatic logic [1:0] top_bit(logic [LineW-1:0] v);
    logic [1:0] r;
    if (v[3]) begin
      r = 2'd3;
    end else if (v[2]) begin
      r = 2'd2;
    end else if (v[1]) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

  // Decimal digit of a key code (0..16); shift counts divisions by ten.
  function automatic logic [3:0] key_digit(logic [KeyW-1:0] key, logic [DigitW-1:0] shift);
    logic            tens;
    logic [KeyW-1:0] ones;
    logic [3:0]      d;
    tens = (key >= KeyW'(10));
    ones = tens ? (key - KeyW'(10)) : key;
    if (shift == '0) begin
      d = ones[3:0];
    end else if (shift == DigitW'(1)) begin
      d = {3'b000, tens};
    end else begin
      d = 4'd0;
    end
    return d;
  endfunction

  function automatic logic [ByteW-1:0] seg_pattern(logic [3:0] d);
    logic [ByteW-1:0] s;
    if (d > 4'd9) begin
      s = SegBlank;
    end else begin
      s = SegTable[d];
    end
    return s;
  endfunction

endpackage

// ===== src/kssm_in_if.sv =====
`timescale 1ns / 1ps
// Interface: input channel carrying the sampled keypad line nibbles.
interface kssm_in_if;
  import kssm_pkg::*;

  logic             valid;
  logic             ready;
  logic [LineW-1:0] key_low_lines;
  logic [LineW-1:0] key_high_lines;

  modport source (output valid, output key_low_lines, output key_high_lines, input ready);
  modport sink   (input valid, input key_low_lines, input key_high_lines, output ready);
endinterface

// ===== src/kssm_out_if.sv =====
`timescale 1ns / 1ps
// Interface: result channel carrying digit enable, segments and key code.
interface kssm_out_if;
  import kssm_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] digit_enable;
  logic [ByteW-1:0] segments;
  logic [KeyW-1:0]  key_code;

  modport source (output valid, output digit_enable, output segments, output key_code,
                  input ready);
  modport sink   (input valid, input digit_enable, input segments, input key_code,
                  output ready);
endinterface

// ===== src/kssm_key_decode.sv =====
`timescale 1ns / 1ps
// Scan phase counter and keypad decode; holds the key of the last scan (KeyNone if none pressed).
module kssm_key_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kssm_pkg::PeriodW-1:0]  cfg_data_i,
  input  logic                          advance_i,
  input  logic [kssm_pkg::LineW-1:0]    key_low_lines_i,
  input  logic [kssm_pkg::LineW-1:0]    key_high_lines_i,
  output logic [kssm_pkg::KeyW-1:0]     key_o
);
  import kssm_pkg::*;

  logic [PeriodW-1:0] period_q;
  logic [PeriodW-1:0] phase_q, phase_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [PeriodW-1:0] period_eff;
  logic [PeriodW:0]   phase_inc;
  logic [LineW-1:0]   low_act, high_act;
  logic [1:0]         row;
  logic [2:0]         col;

  always_comb begin
    low_act    = ~key_low_lines_i;
    high_act   = ~key_high_lines_i;
    row        = 2'd3 - top_bit(high_act);
    col        = 3'd4 - {1'b0, top_bit(low_act)};
    period_eff = (period_q == '0) ? PeriodW'(1) : period_q;
    phase_inc  = {1'b0, phase_q} + (PeriodW+1)'(1);

    key_d = key_q;
    if (phase_q == '0) begin
      if (low_act != '0) begin
        key_d = KeyW'({row, 2'b00}) + KeyW'(col);
      end else begin
        key_d = KeyNone;
      end
    end

    phase_d = (phase_inc >= {1'b0, period_eff}) ? '0 : phase_inc[PeriodW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= ScanPeriodReset;
      phase_q  <= '0;
      key_q    <= KeyNone;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      if (advance_i) begin
        phase_q <= phase_d;
        key_q   <= key_d;
      end
    end
  end

  // Key as it stands after this item's decode.
  assign key_o = key_d;

endmodule

// ===== src/kssm_digit_mux.sv =====
`timescale 1ns / 1ps
// Digit rotation and seven-segment result register.
module kssm_digit_mux (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [kssm_pkg::KeyW-1:0]   key_i,
  output logic [kssm_pkg::ByteW-1:0]  digit_enable_o,
  output logic [kssm_pkg::ByteW-1:0]  segments_o,
  output logic [kssm_pkg::KeyW-1:0]   key_code_o
);
  import kssm_pkg::*;

  logic [DigitW-1:0] pos_q, pos_d;
  logic [DigitW-1:0] shift;
  logic [ByteW-1:0]  enable_d, seg_d;
  logic [ByteW-1:0]  enable_q, seg_q;
  logic [KeyW-1:0]   key_code_q;

  always_comb begin
    shift    = DigitW'(NUM_DIGITS - 1) - pos_q;
    enable_d = ~(ByteW'(1) << pos_q);
    seg_d    = seg_pattern(key_digit(key_i, shift));
    pos_d    = (pos_q == DigitW'(NUM_DIGITS - 1)) ? '0 : pos_q + DigitW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (advance_i) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      enable_q   <= enable_d;
      seg_q      <= seg_d;
      key_code_q <= key_i;
    end
  end

  assign digit_enable_o = enable_q;
  assign segments_o     = seg_q;
  assign key_code_o     = key_code_q;

endmodule

// ===== src/keypad_scan_seven_segment_mux_core.sv =====
`timescale 1ns / 1ps
// Top level: keypad scanner with multiplexed seven-segment display driver.
//
// Usage
//   in_i  : one item per timer tick, carrying the sampled active-low keypad
//           nibbles (key_low_lines = columns, key_high_lines = rows).
//   out_o : one item per input item: active-low digit enable, active-low
//           segment pattern of that decimal digit of the key, and key code.
//   cfg   : cfg_we_i / cfg_data_i write scan_period (ticks between scans,
//           0 behaves as 1). Write only while no item is in flight.
// Timing
//   An item accepted at a clock edge is registered and shown on out_o right
//   after that edge. Throughput is one item per cycle while out_o takes its
//   results; the whole decode (priority encode, digit split, segment lookup)
//   sits between the input handshake and the single result register.
// Reset
//   Scan period returns to 20, scan phase, digit position and key to zero;
//   the result register comes up empty.
// Stall
//   While out_o is held off, the result register keeps its item and in_i
//   ready drops; ready rises again in the cycle the result is taken.
module keypad_scan_seven_segment_mux_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kssm_pkg::PeriodW-1:0]  cfg_data_i,
  kssm_in_if.sink                       in_i,
  kssm_out_if.source                    out_o
);
  import kssm_pkg::*;

  logic            out_valid_q;
  logic            accept;
  logic [KeyW-1:0] key_now;

  // Result slot is free when empty or being drained this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  kssm_key_decode u_decode (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .advance_i        (accept),
    .key_low_lines_i  (in_i.key_low_lines),
    .key_high_lines_i (in_i.key_high_lines),
    .key_o            (key_now)
  );

  kssm_digit_mux u_digit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (accept),
    .key_i          (key_now),
    .digit_enable_o (out_o.digit_enable),
    .segments_o     (out_o.segments),
    .key_code_o     (out_o.key_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;

  // Every accepted item produces a result the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted item produced no result");

  // A waiting result blocks input until it is taken.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted over a stalled result");

  // Exactly one digit enable is low, all upper bits high.
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones(~out_o.digit_enable) == 1 &&
                     ~out_o.digit_enable[ByteW-1:NUM_DIGITS] == '0))
    else $error("digit enable not one-cold");

  // Decimal point off and key code in range.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_o.segments[ByteW-1] && out_o.key_code <= KeyMax))
    else $error("segment or key code out of range");

endmodule
